FILE: rtl/core/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg
// Types and fixed widths shared by the echo canceller modules.
// ----------------------------------------------------------------------------
package lec_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 48;
    localparam int FRAC_W     = 40;
    localparam int STEP_W     = 16;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int COEF_W     = STEP_W + 1 + ERR_W;
    localparam int PROD_W     = WEIGHT_W + SAMPLE_W;
    localparam int UPD_SHIFT  = 8;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1407;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_MWAIT,
        S_UPD,
        S_UWAIT
    } t_state;

    typedef struct packed {
        logic acc_clr;
        logic mac_issue;
        logic upd_issue;
        logic err_load;
    } t_dp_ctl;

    typedef struct packed {
        logic busy;
        logic wr_en;
    } t_dp_sts;

endpackage

FILE: rtl/core/lec_ram.sv
// ----------------------------------------------------------------------------
// lec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lec_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 160,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lec_dp.sv
// ----------------------------------------------------------------------------
// lec_dp
// Shared multiplier pipeline: accumulates the echo estimate on the filter
// pass, forms the error, and produces saturated weight write-backs on the
// adaptation pass.
// ----------------------------------------------------------------------------
module lec_dp #(
    parameter int TAPS  = 160,
    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lec_pkg::t_dp_ctl              i_ctl,
    input  logic [AW-1:0]                 i_idx,
    input  logic [lec_pkg::STEP_W-1:0]    i_step,
    input  logic [lec_pkg::SAMPLE_W-1:0]  i_near,
    input  logic [lec_pkg::WEIGHT_W-1:0]  i_w_rdata,
    input  logic [lec_pkg::SAMPLE_W-1:0]  i_x_rdata,
    output lec_pkg::t_dp_sts              o_sts,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [lec_pkg::WEIGHT_W-1:0]  o_wr_data,
    output logic [lec_pkg::SAMPLE_W-1:0]  o_err_sat
);

    import lec_pkg::*;

    localparam int ACC_W = PROD_W + AW + 1;
    localparam int SUM_W = WEIGHT_W + 2;

    logic                       r_mac_v1, r_upd_v1, r_mac_v2, r_upd_v2;
    logic [AW-1:0]              r_idx1, r_idx2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [WEIGHT_W-1:0] r_w2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [COEF_W-1:0]   r_coef;

    logic signed [WEIGHT_W-1:0] mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic                       est_adj;
    logic [SAMPLE_W-1:0]        est;
    logic signed [ERR_W-1:0]    err;
    logic signed [PROD_W-1:0]   delta;
    logic signed [SUM_W-1:0]    w_sum;
    logic [WEIGHT_W-1:0]        w_new;

    // estimate truncated toward zero, low 16 bits
    assign est_adj = r_acc[ACC_W-1] & (|r_acc[FRAC_W-1:0]);
    assign est     = r_acc[FRAC_W +: SAMPLE_W] + {{(SAMPLE_W-1){1'b0}}, est_adj};
    assign err     = $signed({i_near[SAMPLE_W-1], i_near}) - $signed({est[SAMPLE_W-1], est});

    assign mul_a = r_mac_v1 ? $signed(i_w_rdata)
                            : WEIGHT_W'(r_coef);
    assign mul_p = mul_a * $signed(i_x_rdata);

    assign delta = r_prod >>> UPD_SHIFT;
    assign w_sum = $signed({{2{r_w2[WEIGHT_W-1]}}, r_w2}) + delta[SUM_W-1:0];

    always_comb begin
        if (w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:WEIGHT_W-1])) begin
            w_new = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else if (!w_sum[SUM_W-1] && (|w_sum[SUM_W-2:WEIGHT_W-1])) begin
            w_new = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
    end

    always_comb begin
        if (err[ERR_W-1] != err[ERR_W-2]) begin
            o_err_sat = {err[ERR_W-1], {(SAMPLE_W-1){~err[ERR_W-1]}}};
        end else begin
            o_err_sat = err[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_v1 <= 1'b0;
            r_upd_v1 <= 1'b0;
            r_mac_v2 <= 1'b0;
            r_upd_v2 <= 1'b0;
        end else begin
            r_mac_v1 <= i_ctl.mac_issue;
            r_upd_v1 <= i_ctl.upd_issue;
            r_mac_v2 <= r_mac_v1;
            r_upd_v2 <= r_upd_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_prod <= mul_p;
        r_w2   <= $signed(i_w_rdata);
        r_coef <= $signed({1'b0, i_step}) * r_err;
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_mac_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.err_load) begin
            r_err <= err;
        end
    end

    assign o_sts.busy  = r_mac_v1 | r_mac_v2 | r_upd_v1 | r_upd_v2;
    assign o_sts.wr_en = r_upd_v2;
    assign o_wr_addr   = r_idx2;
    assign o_wr_data   = w_new;

endmodule

FILE: rtl/core/lms_echo_canceller.sv
// ----------------------------------------------------------------------------
// lms_echo_canceller
// LMS adaptive FIR echo canceller: delay line and weights in RAM, one filter
// pass and one adaptation pass per sample pair.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)                   transfer
//  s_axis    in   far_sample[15:0], near_sample[31:16]  tvalid & tready
//  m_axis    out  echo_free_sample[15:0]                tvalid & tready
//  cfg       in   step_size[15:0]                       i_cfg_we
//
//  Each sample pair gets a filter pass and an adaptation pass; each pass
//  reads one tap per cycle through the single read port of each RAM and
//  then drains the pipeline. The next pair is accepted only in idle, once
//  both passes are done. After reset a clearing pass zeroes both RAMs;
//  s_axis_tready stays low meanwhile. A result waits in the output
//  register; the error is formed only once that register is free.
// ----------------------------------------------------------------------------
module lms_echo_canceller #(
    parameter int TAPS = 160
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lec_pkg::STEP_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // far_sample, near_sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata    // echo_free_sample
);

    import lec_pkg::*;

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);
    localparam logic [AW:0]   TAPS_W   = (AW + 1)'(TAPS);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_head, n_head;
    logic [STEP_W-1:0]     r_step;
    logic [SAMPLE_W-1:0]   r_near;
    logic                  r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0]   r_odata;

    t_dp_ctl               ctl;
    t_dp_sts               sts;
    logic                  in_xfer, out_free;
    logic [AW:0]           x_sum;
    logic [AW-1:0]         x_raddr;
    logic                  w_we, x_we;
    logic [AW-1:0]         w_waddr, x_waddr, dp_waddr;
    logic [WEIGHT_W-1:0]   w_wdata, w_rdata, dp_wdata;
    logic [SAMPLE_W-1:0]   x_wdata, x_rdata, err_sat;

    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign out_free = ~r_ovalid | m_axis_tready;

    assign x_sum   = {1'b0, r_head} + {1'b0, r_idx};
    assign x_raddr = (x_sum >= TAPS_W) ? AW'(x_sum - TAPS_W) : x_sum[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_idx == LAST_IDX) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_MAC;
            S_MAC:   if (r_idx == LAST_IDX) n_state = S_MWAIT;
            S_MWAIT: if (!sts.busy && out_free) n_state = S_UPD;
            S_UPD:   if (r_idx == LAST_IDX) n_state = S_UWAIT;
            S_UWAIT: if (!sts.busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl           = '0;
        s_axis_tready = 1'b0;
        n_idx         = r_idx;
        n_head        = r_head;
        w_we          = sts.wr_en;
        w_waddr       = dp_waddr;
        w_wdata       = dp_wdata;
        x_we          = 1'b0;
        x_waddr       = r_head;
        x_wdata       = s_axis_tdata[SAMPLE_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = '0;
                x_we    = 1'b1;
                x_waddr = r_idx;
                x_wdata = '0;
                n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                x_we          = in_xfer;
                ctl.acc_clr   = in_xfer;
                n_idx         = '0;
            end
            S_MAC: begin
                ctl.mac_issue = 1'b1;
                n_idx         = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            S_MWAIT: begin
                ctl.err_load = ~sts.busy & out_free;
                n_idx        = '0;
            end
            S_UPD: begin
                ctl.upd_issue = 1'b1;
                n_idx         = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            S_UWAIT: begin
                if (!sts.busy) begin
                    n_head = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    assign n_ovalid = ctl.err_load | (r_ovalid & ~m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_head   <= '0;
            r_step   <= STEP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    // payload: hold near sample for the pass, load result when formed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_near <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (ctl.err_load) begin
            r_odata <= err_sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    lec_ram #(
        .W     (WEIGHT_W),
        .DEPTH (TAPS)
    ) u_w_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    lec_ram #(
        .W     (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (x_waddr),
        .i_wdata (x_wdata),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    lec_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_idx     (r_idx),
        .i_step    (r_step),
        .i_near    (r_near),
        .i_w_rdata (w_rdata),
        .i_x_rdata (x_rdata),
        .o_sts     (sts),
        .o_wr_addr (dp_waddr),
        .o_wr_data (dp_wdata),
        .o_err_sat (err_sat)
    );

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !sts.busy)
        else $error("pipeline busy while idle");

    a_wb_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.wr_en |-> (r_state == S_UPD || r_state == S_UWAIT))
        else $error("weight write-back outside adaptation pass");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("delay line head out of range");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.err_load |=> m_axis_tvalid)
        else $error("result not presented after error load");

endmodule

FILE: tb/lec_echo_checker.sv
// ----------------------------------------------------------------------------
// lec_echo_checker
// Watches the sample and result streams of the echo canceller. Keeps its own
// copy of the delay line, tap weights and step size, computes the expected
// echo-free sample of every accepted sample pair, and compares each result
// transfer with the oldest expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lec_echo_checker #(
    parameter int TAPS = 160
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lec_pkg::STEP_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [31:0]                   i_s_tdata,    // far_sample, near_sample
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [15:0]                   i_m_tdata,    // echo_free_sample
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);
    import lec_pkg::*;

    localparam longint W_MAX  = (64'sd1 <<< (WEIGHT_W - 1)) - 1;
    localparam longint W_MIN  = -W_MAX - 1;
    localparam int     OUT_HI = 2 ** (SAMPLE_W - 1) - 1;
    localparam int     OUT_LO = -(2 ** (SAMPLE_W - 1));

    logic [STEP_W-1:0]          step_size;
    logic signed [SAMPLE_W-1:0] far_line [TAPS];
    logic signed [WEIGHT_W-1:0] tap_w [TAPS];
    logic signed [SAMPLE_W-1:0] echo_free_q [$];

    task automatic cancel_echo(input logic signed [SAMPLE_W-1:0] far,
                               input logic signed [SAMPLE_W-1:0] near,
                               output logic signed [SAMPLE_W-1:0] echo_free);
        logic signed [79:0] acc;
        logic signed [79:0] quo;
        longint             prod;
        longint             w_next;
        int                 err;
        int                 i;
        far_line[0] = far;
        acc = '0;
        for (i = 0; i < TAPS; i++) begin
            prod = longint'(tap_w[i]) * longint'(far_line[i]);
            acc  = acc + prod;
        end
        // truncate toward zero, then wrap to sample width
        if (acc < 0) begin
            quo = -((-acc) >>> FRAC_W);
        end else begin
            quo = acc >>> FRAC_W;
        end
        err = int'(near) - int'($signed(quo[SAMPLE_W-1:0]));
        for (i = 0; i < TAPS; i++) begin
            prod = (longint'(step_size) * longint'(err) * longint'(far_line[i])) >>> UPD_SHIFT;
            w_next = longint'(tap_w[i]) + prod;
            if (w_next > W_MAX) begin
                w_next = W_MAX;
            end else if (w_next < W_MIN) begin
                w_next = W_MIN;
            end
            tap_w[i] = w_next[WEIGHT_W-1:0];
        end
        for (i = TAPS - 1; i > 0; i--) begin
            far_line[i] = far_line[i-1];
        end
        if (err > OUT_HI) begin
            echo_free = OUT_HI[SAMPLE_W-1:0];
        end else if (err < OUT_LO) begin
            echo_free = OUT_LO[SAMPLE_W-1:0];
        end else begin
            echo_free = err[SAMPLE_W-1:0];
        end
    endtask

    always @(posedge i_clk) begin : monitor
        logic signed [SAMPLE_W-1:0] expected;
        int                         i;
        if (!i_rst_n) begin
            step_size = STEP_RESET;
            for (i = 0; i < TAPS; i++) begin
                far_line[i] = '0;
                tap_w[i]    = '0;
            end
            echo_free_q.delete();
        end else begin
            if (i_cfg_we) begin
                step_size = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                cancel_echo(i_s_tdata[15:0], i_s_tdata[31:16], expected);
                echo_free_q.push_back(expected);
            end
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                if (echo_free_q.size() == 0) begin
                    $error("echo_free_sample: unexpected transfer, actual %0d",
                           $signed(i_m_tdata));
                    o_fail_count++;
                end else begin
                    expected = echo_free_q.pop_front();
                    if (i_m_tdata !== expected) begin
                        $error("echo_free_sample: expected %0d, actual %0d",
                               expected, $signed(i_m_tdata));
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = echo_free_q.size();
    end

endmodule

FILE: tb/lms_echo_canceller_tb.sv
// ----------------------------------------------------------------------------
// lms_echo_canceller_tb
// Drives sample pairs into the echo canceller under random source gaps and
// sink stalls, across a range of step sizes from 0 to 65535. A separate
// checker predicts every echo-free sample; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lms_echo_canceller_tb;
    import lec_pkg::*;

    localparam int TAPS       = 160;
    localparam int LATENCY    = 2 * TAPS + 7;
    localparam int HOLD_LEN   = 3000;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 153;
    localparam int N_DIR_SLOW = 14;
    localparam int N_DIR_FAST = 6;

    // {near_sample, far_sample}
    localparam logic [31:0] DIR_SLOW [N_DIR_SLOW] = '{
        32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF, 32'h7FFF_8000,
        32'hFFFF_0001, 32'h0001_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, 32'h7FFF_0000,
        32'h8000_0000, 32'hFF00_00FF, 32'h00FF_FF00, 32'hFFFF_FFFF
    };
    // drive the weights hard so the error saturates both ways
    localparam logic [31:0] DIR_FAST [N_DIR_FAST] = '{
        32'h8000_7FFF, 32'h7FFF_0000, 32'h8000_8000, 32'h8000_0000, 32'h7FFF_7FFF,
        32'h0000_0000
    };
    localparam logic [STEP_W-1:0] PHASE_STEP [N_PHASES] = '{
        STEP_RESET, 16'd0, 16'd4000, 16'd1, 16'd0, 16'd300, 16'hFFFF, 16'h8000
    };
    localparam logic [15:0] EXTREMES [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [STEP_W-1:0] i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;

    int fail_count;
    int pending;
    int result_count;

    bit tx_nogap   = 1'b0;
    bit rx_nostall = 1'b0;
    bit hold_req   = 1'b0;
    int hold_count = 0;
    int sent_count = 0;
    int step_count = 0;

    lms_echo_canceller #(
        .TAPS (TAPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lec_echo_checker #(
        .TAPS (TAPS)
    ) u_echo_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(64'd20_000_000);
        $display("Mismatches found");
        $finish;
    end

    // result sink: random stall per transfer, one long hold on request
    initial begin : sink
        int wait_cycles;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
                hold_count++;
            end else if (!rx_nostall) begin
                wait_cycles = $urandom_range(0, 11);
                if (wait_cycles > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_pair(input logic [15:0] far, input logic [15:0] near);
        int gap;
        gap = tx_nogap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {near, far};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // drain all results and let the adaptation pass finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        step_count++;
    endtask

    initial begin : stimulus
        logic signed [15:0] far_recent [16];
        logic [15:0]        far;
        logic [15:0]        near;
        logic [STEP_W-1:0]  step_sel;
        int                 mode;
        int                 echo_lag;
        int                 echo_shift;
        int                 tmp;
        int                 p;
        int                 n;
        int                 k;

        for (k = 0; k < 16; k++) far_recent[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        settle();
        write_step(STEP_RESET);
        for (n = 0; n < N_DIR_SLOW; n++) send_pair(DIR_SLOW[n][15:0], DIR_SLOW[n][31:16]);
        settle();
        write_step(16'hFFFF);
        for (n = 0; n < N_DIR_FAST; n++) send_pair(DIR_FAST[n][15:0], DIR_FAST[n][31:16]);

        for (p = 0; p < N_PHASES; p++) begin
            settle();
            step_sel = (p == 4) ? STEP_W'($urandom_range(0, 65535)) : PHASE_STEP[p];
            write_step(step_sel);
            tx_nogap   = (p == 2 || p == 5);
            rx_nostall = (p == 3 || p == 5);
            echo_lag   = $urandom_range(0, 15);
            echo_shift = $urandom_range(0, 3);
            for (n = 0; n < PHASE_LEN; n++) begin
                if (p == 1 && n == PHASE_LEN / 2) hold_req = 1'b1;
                mode = $urandom_range(0, 9);
                far  = 16'($urandom);
                if (mode == 6) begin
                    far = EXTREMES[$urandom_range(0, 4)];
                end else if (mode >= 7) begin
                    tmp = int'($urandom_range(0, 511)) - 256;
                    far = tmp[15:0];
                end
                for (k = 15; k > 0; k--) far_recent[k] = far_recent[k-1];
                far_recent[0] = far;
                if (mode < 4) begin
                    tmp  = (int'(far_recent[echo_lag]) >>> echo_shift)
                           + int'($urandom_range(0, 64)) - 32;
                    near = tmp[15:0];
                end else if (mode < 6) begin
                    near = 16'($urandom);
                end else if (mode == 6) begin
                    near = EXTREMES[$urandom_range(0, 4)];
                end else begin
                    tmp  = int'($urandom_range(0, 511)) - 256;
                    near = tmp[15:0];
                end
                send_pair(far, near);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);

        if (pending != 0) $error("echo_free_sample: %0d results never arrived", pending);
        $display("Sent %0d sample pairs under %0d step_size writes, 0 and 65535 included,",
                 sent_count, step_count);
        $display("and checked %0d echo_free_sample transfers across %0d long sink hold(s).",
                 result_count, hold_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lec_pkg.sv
rtl/core/lec_ram.sv
rtl/core/lec_dp.sv
rtl/core/lms_echo_canceller.sv
tb/lec_echo_checker.sv
tb/lms_echo_canceller_tb.sv
